>>> src/sorted_pair_key_table_core_macros.svh
// Assertion macros shared by the table core.
`ifndef SORTED_PAIR_KEY_TABLE_CORE_MACROS_SVH
`define SORTED_PAIR_KEY_TABLE_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SPK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/spkt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spkt_pkg;
  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  localparam logic [2:0] OpAppend = 3'd0;
  localparam logic [2:0] OpSet    = 3'd1;
  localparam logic [2:0] OpSort   = 3'd2;
  localparam logic [2:0] OpFind   = 3'd3;
  localparam logic [2:0] OpClear  = 3'd4;

  localparam logic [1:0] KindInt  = 2'd0;
  localparam logic [1:0] KindStr  = 2'd1;
  localparam logic [1:0] KindDrop = 2'd2;
  localparam logic [1:0] KindRsvd = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StMiss     = 2'd1;
  localparam logic [1:0] StUnsorted = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] key;
    logic [31:0] value;
  } row_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] owner_id;
    logic [15:0] param_key;
    logic [31:0] param_value;
    logic [1:0]  value_kind;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] found_value;
    logic [1:0]  status;
    logic [12:0] row_count;
  } rsp_t;
endpackage
`default_nettype wire

>>> src/spkt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface spkt_req_if;
  logic valid;
  logic ready;
  spkt_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface spkt_rsp_if;
  logic valid;
  logic ready;
  spkt_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/spkt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Single-port row memory with registered read data.
module spkt_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write or read one row per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> src/sorted_pair_key_table_core.sv
// Append, clear and unknown codes answer straight from idle; find runs a
// binary search over sorted rows; set scans the rows in order; sort runs
// merge passes through a scratch bank and copies back. The single-port row memories and one shared
// compare unit serialise this work. One request at a time; ready is low while
// one is in work. Reset clears the row count and the sorted flag at once;
// row memory is not cleared and rows beyond the count are never used.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_pair_key_table_core_macros.svh"
module sorted_pair_key_table_core (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  spkt_req_if.sink     req_i,
  spkt_rsp_if.source   rsp_o
);
  localparam int unsigned IdxW = spkt_pkg::IdxW;
  localparam int unsigned CntW = spkt_pkg::CntW;
  localparam int unsigned RowW = $bits(spkt_pkg::row_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SET_RD, S_SET_CHK, S_FIND_RD, S_FIND_CHK,
    S_MRG_RDA, S_MRG_RDB, S_MRG_CMP, S_MRG_WR, S_CPY_RD, S_CPY_WR, S_RESP
  } state_e;

  state_e state_q;
  spkt_pkg::req_t req_q;
  logic [CntW-1:0] count_q;
  logic sorted_q;
  spkt_pkg::rsp_t rsp_q;
  logic [CntW-1:0] idx_q;
  logic [CntW-1:0] lo_q, hi_q;
  logic [CntW-1:0] width_q, a_q, b_q, mid_q, end_q, d_q;
  spkt_pkg::row_t row_a_q;

  // Main rows and a scratch bank for the merge passes.
  logic main_we, tmp_we;
  logic [IdxW-1:0] main_addr, tmp_addr;
  spkt_pkg::row_t main_wdata, tmp_wdata, main_rdata, tmp_rdata;

  spkt_ram #(.Depth(spkt_pkg::TableDepth), .Width(RowW)) u_main (
    .clk_i(clk_i), .we_i(main_we), .addr_i(main_addr),
    .wdata_i(main_wdata), .rdata_o(main_rdata)
  );
  spkt_ram #(.Depth(spkt_pkg::TableDepth), .Width(RowW)) u_tmp (
    .clk_i(clk_i), .we_i(tmp_we), .addr_i(tmp_addr),
    .wdata_i(tmp_wdata), .rdata_o(tmp_rdata)
  );

  // Shared pair compare unit.
  logic [31:0] cmp_l, cmp_r;
  logic cmp_lt, cmp_eq;
  assign cmp_lt = cmp_l < cmp_r;
  assign cmp_eq = cmp_l == cmp_r;

  logic [CntW-1:0] fmid;
  logic [CntW:0] fsum;
  assign fsum = {1'b0, lo_q} + {1'b0, hi_q};
  assign fmid = fsum[CntW:1];

  logic full;
  assign full = count_q == CntW'(spkt_pkg::TableDepth);

  // An append keeps its row only for the integer and string kinds.
  logic kind_keep;
  assign kind_keep = req_i.payload.value_kind == spkt_pkg::KindInt ||
                     req_i.payload.value_kind == spkt_pkg::KindStr;

  assign req_i.ready = state_q == S_IDLE;
  assign rsp_o.valid = state_q == S_RESP;
  assign rsp_o.payload = rsp_q;

  // First response and next state for a request taken in idle.
  spkt_pkg::rsp_t idle_rsp;
  state_e idle_state;
  always_comb begin
    idle_rsp = '{found: 1'b0, found_value: 32'd0, status: spkt_pkg::StOk,
                 row_count: 13'(count_q)};
    idle_state = S_RESP;
    case (req_i.payload.operation)
      spkt_pkg::OpAppend: begin
        if (kind_keep) begin
          if (full) begin
            idle_rsp.status = spkt_pkg::StFull;
          end else begin
            idle_rsp.row_count = 13'(count_q + 1'b1);
          end
        end
      end
      spkt_pkg::OpSet: idle_state = S_SET_RD;
      spkt_pkg::OpSort: begin
        if (count_q > CntW'(1)) idle_state = S_MRG_RDA;
      end
      spkt_pkg::OpFind: begin
        if (count_q == '0) begin
          idle_rsp.status = spkt_pkg::StMiss;
        end else if (!sorted_q) begin
          idle_rsp.status = spkt_pkg::StUnsorted;
        end else begin
          idle_rsp.status = spkt_pkg::StMiss;
          idle_state = S_FIND_RD;
        end
      end
      spkt_pkg::OpClear: idle_rsp.row_count = '0;
      default: ;
    endcase
  end

  // Operand and memory port selection.
  always_comb begin
    main_we = 1'b0;
    tmp_we = 1'b0;
    main_addr = idx_q[IdxW-1:0];
    tmp_addr = d_q[IdxW-1:0];
    main_wdata = '{owner: req_q.owner_id, key: req_q.param_key, value: req_q.param_value};
    tmp_wdata = row_a_q;
    cmp_l = {req_q.owner_id, req_q.param_key};
    cmp_r = {main_rdata.owner, main_rdata.key};
    unique case (state_q)
      S_IDLE: begin
        main_addr = count_q[IdxW-1:0];
        main_wdata = '{owner: req_i.payload.owner_id, key: req_i.payload.param_key,
                       value: (req_i.payload.value_kind == spkt_pkg::KindStr) ? 32'd0
                              : req_i.payload.param_value};
        main_we = req_i.valid && !full &&
                  req_i.payload.operation == spkt_pkg::OpAppend && kind_keep;
      end
      S_SET_CHK: begin
        main_we = ((idx_q < count_q) && cmp_eq) || ((idx_q == count_q) && !full);
      end
      S_FIND_RD: main_addr = fmid[IdxW-1:0];
      S_MRG_RDA: main_addr = a_q[IdxW-1:0];
      S_MRG_RDB: main_addr = b_q[IdxW-1:0];
      S_MRG_CMP: begin
        cmp_l = {row_a_q.owner, row_a_q.key};
        cmp_r = {main_rdata.owner, main_rdata.key};
      end
      S_MRG_WR: tmp_we = 1'b1;
      S_CPY_RD: tmp_addr = idx_q[IdxW-1:0];
      S_CPY_WR: begin
        main_addr = idx_q[IdxW-1:0];
        main_wdata = tmp_rdata;
        main_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      sorted_q <= 1'b0;
      req_q <= '0;
      rsp_q <= '0;
      idx_q <= '0;
      lo_q <= '0;
      hi_q <= '0;
      width_q <= '0;
      a_q <= '0;
      b_q <= '0;
      mid_q <= '0;
      end_q <= '0;
      d_q <= '0;
      row_a_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            req_q <= req_i.payload;
            rsp_q <= idle_rsp;
            idx_q <= '0;
            state_q <= idle_state;
            case (req_i.payload.operation)
              spkt_pkg::OpAppend: begin
                sorted_q <= 1'b0;
                if (kind_keep && !full) count_q <= count_q + 1'b1;
              end
              spkt_pkg::OpSort: begin
                sorted_q <= 1'b1;
                width_q <= CntW'(1);
                a_q <= '0;
                b_q <= CntW'(1);
                mid_q <= CntW'(1);
                end_q <= (count_q < CntW'(2)) ? count_q : CntW'(2);
                d_q <= '0;
              end
              spkt_pkg::OpFind: begin
                lo_q <= '0;
                hi_q <= count_q - 1'b1;
              end
              spkt_pkg::OpClear: begin
                count_q <= '0;
                sorted_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_SET_RD: state_q <= S_SET_CHK;
        S_SET_CHK: begin
          if (idx_q < count_q) begin
            if (cmp_eq) begin
              state_q <= S_RESP;
            end else begin
              idx_q <= idx_q + 1'b1;
              state_q <= S_SET_RD;
            end
          end else begin
            sorted_q <= 1'b0;
            state_q <= S_RESP;
            if (full) begin
              rsp_q.status <= spkt_pkg::StFull;
            end else begin
              count_q <= count_q + 1'b1;
              rsp_q.row_count <= 13'(count_q + 1'b1);
            end
          end
        end
        S_FIND_RD: begin
          mid_q <= fmid;
          state_q <= S_FIND_CHK;
        end
        S_FIND_CHK: begin
          if (cmp_eq) begin
            rsp_q.found <= 1'b1;
            rsp_q.found_value <= main_rdata.value;
            rsp_q.status <= spkt_pkg::StOk;
            state_q <= S_RESP;
          end else if (!cmp_lt) begin
            // Probe is below the wanted pair.
            if (mid_q == hi_q) state_q <= S_RESP;
            else begin
              lo_q <= mid_q + 1'b1;
              state_q <= S_FIND_RD;
            end
          end else begin
            if (mid_q == lo_q) state_q <= S_RESP;
            else begin
              hi_q <= mid_q - 1'b1;
              state_q <= S_FIND_RD;
            end
          end
        end
        S_MRG_RDA: state_q <= S_MRG_RDB;
        S_MRG_RDB: begin
          row_a_q <= main_rdata;
          state_q <= S_MRG_CMP;
        end
        S_MRG_CMP: begin
          // Pick the next merged row; equal pairs take the left run.
          if (a_q >= mid_q || (b_q < end_q && !cmp_lt && !cmp_eq)) begin
            row_a_q <= main_rdata;
            b_q <= b_q + 1'b1;
          end else begin
            a_q <= a_q + 1'b1;
          end
          state_q <= S_MRG_WR;
        end
        S_MRG_WR: begin
          d_q <= d_q + 1'b1;
          if (d_q + 1'b1 < end_q) begin
            state_q <= S_MRG_RDA;
          end else if ({1'b0, end_q} < {1'b0, count_q}) begin
            a_q <= end_q;
            mid_q <= ({1'b0, end_q} + {1'b0, width_q} < {1'b0, count_q}) ?
                     end_q + width_q : count_q;
            end_q <= ({1'b0, end_q} + {width_q, 1'b0} < {1'b0, count_q}) ?
                     CntW'({1'b0, end_q} + {width_q, 1'b0}) : count_q;
            b_q <= ({1'b0, end_q} + {1'b0, width_q} < {1'b0, count_q}) ?
                   end_q + width_q : count_q;
            state_q <= S_MRG_RDA;
          end else begin
            idx_q <= '0;
            state_q <= S_CPY_RD;
          end
        end
        S_CPY_RD: state_q <= S_CPY_WR;
        S_CPY_WR: begin
          if (idx_q + 1'b1 < count_q) begin
            idx_q <= idx_q + 1'b1;
            state_q <= S_CPY_RD;
          end else if ({width_q, 1'b0} < {1'b0, count_q}) begin
            width_q <= width_q << 1;
            a_q <= '0;
            d_q <= '0;
            mid_q <= ({width_q, 1'b0} < {1'b0, count_q}) ? CntW'({width_q, 1'b0}) : count_q;
            b_q <= CntW'({width_q, 1'b0});
            end_q <= ({width_q, 2'b00} < {2'b00, count_q}) ? CntW'({width_q, 2'b00}) : count_q;
            state_q <= S_MRG_RDA;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_RESP: if (rsp_o.ready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SPK_ASSERT_IMP(a_rows_bounded, clk_i, rst_ni, 1'b1, count_q <= CntW'(spkt_pkg::TableDepth), "row count beyond depth")
  `SPK_ASSERT_IMP(a_found_ok, clk_i, rst_ni, rsp_o.valid && rsp_o.payload.found, rsp_o.payload.status == spkt_pkg::StOk, "found with bad status")
  `SPK_ASSERT_NEXT(a_sort_sets_flag, clk_i, rst_ni, rsp_o.valid && rsp_o.ready && req_q.operation == spkt_pkg::OpSort, sorted_q, "sort left table unsorted")
endmodule
`default_nettype wire
